// ----- design/pad_pkg.sv -----
// shared types, constants and the tangent table for the point angle block
`default_nettype none

package pad_pkg;

    // coordinate and datapath widths
    localparam int COORD_BITS = 12;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MAG_W      = COORD_BITS;
    localparam int TAN_FRAC   = 34;
    localparam int TAN_W      = 40;
    localparam int PROD_W     = MAG_W + TAN_W;
    localparam int ANGLE_W    = 9;
    localparam int F_MAX      = 89;
    localparam int F_W        = $clog2(F_MAX + 1);
    localparam int SEARCH_STAGES = F_W;

    // series evaluation constants for the tangent table
    localparam int          SER_Q      = 60;
    localparam int          SER_TERMS  = 16;
    localparam logic [63:0] PI_SCALED  = 64'd31415926535;
    localparam logic [63:0] PI_DEN     = 64'd1800000000000;

    // fixed angles
    localparam logic [ANGLE_W-1:0] DEG_0   = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
    localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);

    // signed differences after the first stage
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } t_delta;

    // item carried through the magnitude and search stages
    typedef struct packed {
        logic [MAG_W-1:0] adx;
        logic [MAG_W-1:0] ady;
        logic [F_W-1:0]   f;
        logic             dx_neg;
        logic             dy_neg;
        logic             dx_zero;
        logic             dy_zero;
    } t_item;

    typedef logic [TAN_W-1:0] t_tan_rom [0:F_MAX];

    // (a * b) >> SER_Q, low 64 bits
    function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[SER_Q+63:SER_Q];
    endfunction

    // restoring divide, returns {quotient, remainder}
    function automatic logic [127:0] divmod(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    // floor(num * 2^bits / den)
    function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
                                             input int bits);
        logic [127:0] qr;
        logic [63:0]  q;
        logic [63:0]  r;
        qr = divmod(num, den);
        q  = qr[127:64];
        r  = qr[63:0];
        for (int i = 0; i < bits; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // tangent table with TAN_FRAC fraction bits, built from sine and cosine series
    function automatic t_tan_rom build_tan_rom();
        t_tan_rom    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] st;
        logic [63:0] c;
        logic [63:0] ct;
        logic [63:0] dv;
        logic [127:0] qr;
        logic [63:0] t;
        rom[0] = '0;
        for (int k = 1; k <= F_MAX; k++) begin
            x  = frac_div(64'(k) * PI_SCALED, PI_DEN, SER_Q);
            x2 = mul_q(x, x);
            s  = x;
            st = x;
            c  = 64'd1 << SER_Q;
            ct = 64'd1 << SER_Q;
            for (int i = 1; i <= SER_TERMS; i++) begin
                dv = 64'((2 * i) * (2 * i + 1));
                qr = divmod(mul_q(st, x2), dv);
                st = qr[127:64];
                dv = 64'((2 * i - 1) * (2 * i));
                qr = divmod(mul_q(ct, x2), dv);
                ct = qr[127:64];
                if (i % 2 == 1) begin
                    s = s - st;
                    c = c - ct;
                end else begin
                    s = s + st;
                    c = c + ct;
                end
            end
            t      = (c == 64'd0) ? '1 : frac_div(s, c, TAN_FRAC);
            rom[k] = t[TAN_W-1:0];
        end
        return rom;
    endfunction

    localparam t_tan_rom TAN_ROM = build_tan_rom();

    // table lookup, codes past the last degree read as zero
    function automatic logic [TAN_W-1:0] tan_at(input logic [F_W-1:0] idx);
        logic [TAN_W-1:0] v;
        if (idx > F_W'(F_MAX)) begin
            v = '0;
        end else begin
            v = TAN_ROM[idx];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/pad_front.sv -----
// front stages: coordinate differences, then magnitudes and sign flags
`default_nettype none

module pad_front
    import pad_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_ref_x,
    input  logic signed [COORD_BITS-1:0] i_ref_y,
    input  logic signed [COORD_BITS-1:0] i_pt_x,
    input  logic signed [COORD_BITS-1:0] i_pt_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_item                        o_item
);

    logic   r_a_valid;
    t_delta r_a_delta;
    t_delta n_a_delta;
    logic   r_b_valid;
    t_item  r_b_item;
    t_item  n_b_item;
    logic   ready_a;
    logic   ready_b;

    // stage ready chain
    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;

    // differences, y flipped so angles run counterclockwise on screen
    always_comb begin
        n_a_delta.dx = DIFF_W'(i_pt_x) - DIFF_W'(i_ref_x);
        n_a_delta.dy = DIFF_W'(i_ref_y) - DIFF_W'(i_pt_y);
    end

    // magnitudes and quadrant flags
    always_comb begin
        n_b_item.dx_neg  = r_a_delta.dx[DIFF_W-1];
        n_b_item.dy_neg  = r_a_delta.dy[DIFF_W-1];
        n_b_item.dx_zero = (r_a_delta.dx == '0);
        n_b_item.dy_zero = (r_a_delta.dy == '0);
        n_b_item.adx     = r_a_delta.dx[DIFF_W-1] ? MAG_W'(-r_a_delta.dx)
                                                  : MAG_W'(r_a_delta.dx);
        n_b_item.ady     = r_a_delta.dy[DIFF_W-1] ? MAG_W'(-r_a_delta.dy)
                                                  : MAG_W'(r_a_delta.dy);
        n_b_item.f       = '0;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_delta <= n_a_delta;
        end
        if (ready_b) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

`ifndef SYNTHESIS
    // zero flag agrees with the magnitude
    a_dy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_item.dy_zero == (r_b_item.ady == '0)))
        else $error("dy zero flag disagrees with magnitude");
`endif

endmodule

`default_nettype wire

// ----- design/pad_search.sv -----
// one binary search step over the tangent table
`default_nettype none

module pad_search
    import pad_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [F_W-1:0] i_step,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_item          i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output t_item          o_item
);

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [F_W-1:0]    cand;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    logic              hit;

    assign o_ready = !r_valid || i_ready;

    // try the next bit of the degree count: |dy| * 2^frac >= |dx| * tan(cand)
    always_comb begin
        cand   = i_item.f | i_step;
        lhs    = {{(TAN_W - TAN_FRAC){1'b0}}, i_item.ady, {TAN_FRAC{1'b0}}};
        rhs    = PROD_W'(i_item.adx) * PROD_W'(tan_at(cand));
        hit    = (cand <= F_W'(F_MAX)) && (lhs >= rhs);
        n_item = i_item;
        if (hit) begin
            n_item.f = cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

`ifndef SYNTHESIS
    // lower count bits are still clear when this step sees the item
    a_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_item.f & (i_step - F_W'(1))) == '0))
        else $error("search step sees low count bits already set");
`endif

endmodule

`default_nettype wire

// ----- design/pad_angle.sv -----
// quadrant and axis mapping of the degree count, output register
`default_nettype none

module pad_angle
    import pad_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ANGLE_W-1:0] o_angle_deg
);

    logic               r_valid;
    logic [ANGLE_W-1:0] r_angle;
    logic [ANGLE_W-1:0] n_angle;
    logic [ANGLE_W-1:0] fa;

    assign o_ready = !r_valid || i_ready;

    // axes first, then the four quadrants; a full turn wraps to zero
    always_comb begin
        fa = ANGLE_W'(i_item.f);
        if (i_item.dy_zero) begin
            n_angle = i_item.dx_neg ? DEG_180 : DEG_0;
        end else if (i_item.dx_zero) begin
            n_angle = i_item.dy_neg ? DEG_270 : DEG_90;
        end else if (!i_item.dx_neg && !i_item.dy_neg) begin
            n_angle = fa;
        end else if (i_item.dx_neg && !i_item.dy_neg) begin
            n_angle = DEG_180 - fa;
        end else if (i_item.dx_neg) begin
            n_angle = DEG_180 + fa;
        end else if (fa == DEG_0) begin
            n_angle = DEG_0;
        end else begin
            n_angle = DEG_360 - fa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid     = r_valid;
    assign o_angle_deg = r_angle;

`ifndef SYNTHESIS
    // result stays below a full turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_angle < DEG_360))
        else $error("angle out of range");
`endif

endmodule

`default_nettype wire

// ----- design/point_angle_degrees.sv -----
// Stages: two front stages, seven binary search steps over the 90-entry tangent table,
// one output stage.
// Throughput: one transaction per cycle while i_ready is high; the search stages each
// hold a 12x40 multiply and compare; a stage stalls only when the next one stalls.
// Reset: synchronous active low, clears the stage valid bits; the tangent table is
// constant and needs no clearing, so o_ready is high in the first cycle after reset.
`default_nettype none

module point_angle_degrees
    import pad_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_ref_x,
    input  logic signed [COORD_BITS-1:0] i_ref_y,
    input  logic signed [COORD_BITS-1:0] i_pt_x,
    input  logic signed [COORD_BITS-1:0] i_pt_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ANGLE_W-1:0]           o_angle_deg
);

    logic  chain_valid [0:SEARCH_STAGES];
    logic  chain_ready [0:SEARCH_STAGES];
    t_item chain_item  [0:SEARCH_STAGES];

    // differences and magnitudes
    pad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ref_x (i_ref_x),
        .i_ref_y (i_ref_y),
        .i_pt_x  (i_pt_x),
        .i_pt_y  (i_pt_y),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_item  (chain_item[0])
    );

    // binary search, most significant count bit first
    for (genvar g = 0; g < SEARCH_STAGES; g++) begin : g_search
        logic [F_W-1:0] step;
        assign step = {{(F_W - 1){1'b0}}, 1'b1} << (F_W - 1 - g);

        pad_search u_search (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (step),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_item  (chain_item[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_item  (chain_item[g+1])
        );
    end

    // quadrant mapping and output register
    pad_angle u_angle (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (chain_valid[SEARCH_STAGES]),
        .o_ready     (chain_ready[SEARCH_STAGES]),
        .i_item      (chain_item[SEARCH_STAGES]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_angle_deg (o_angle_deg)
    );

`ifndef SYNTHESIS
    // a ready sink makes the whole pipeline ready
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("pipeline not ready while sink is ready");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the point angle block: directed rows, then random traffic
`default_nettype none

module testbench
    import pad_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_POINTS = 1800;
    localparam int  PHASES        = 4;
    localparam int  LIMIT_CYCLES  = 400000;
    localparam int  DRAIN_CYCLES  = 30;
    localparam int  MAX_PRINTED   = 40;
    localparam int  SEND_IDLE_PCT [PHASES] = '{0, 48, 0, 32};
    localparam int  RECV_STALL_PCT[PHASES] = '{0, 0, 48, 32};

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // one directed row; angle is only used when typed is set
    typedef struct packed {
        t_coord             rx;
        t_coord             ry;
        t_coord             px;
        t_coord             py;
        logic               typed;
        logic [ANGLE_W-1:0] angle;
    } t_point_row;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        int                 seq;
    } t_angle_entry;

    localparam int DIRECTED_ROWS = 25;
    localparam t_point_row DIRECTED[DIRECTED_ROWS] = '{
        // same point
        '{0, 0, 0, 0, 1'b1, 0},
        '{-2048, -2048, -2048, -2048, 1'b1, 0},
        '{2047, 2047, 2047, 2047, 1'b1, 0},
        // horizontal and vertical axes
        '{-2048, 5, 2047, 5, 1'b1, 0},
        '{2047, -7, -2048, -7, 1'b1, 180},
        '{3, 2047, 3, -2048, 1'b1, 90},
        '{3, -2048, 3, 2047, 1'b1, 270},
        // full-range diagonals in each quadrant
        '{-2048, 2047, 2047, -2048, 1'b1, 45},
        '{2047, 2047, -2048, -2048, 1'b1, 135},
        '{2047, -2048, -2048, 2047, 1'b1, 225},
        '{-2048, -2048, 2047, 2047, 1'b1, 315},
        // shallow: quadrant four wraps the full turn to zero
        '{-2048, 0, 2047, 1, 1'b1, 0},
        '{-2048, 1, 2047, 0, 1'b1, 0},
        '{2047, 1, -2048, 0, 1'b1, 180},
        '{2047, 0, -2048, 1, 1'b1, 180},
        // steep: past the last table entry
        '{0, 2047, 1, -2048, 1'b1, 89},
        '{0, 2047, -1, -2048, 1'b1, 91},
        '{0, -2048, -1, 2047, 1'b1, 269},
        '{0, -2048, 1, 2047, 1'b1, 271},
        // general points
        '{100, -50, -300, 400, 1'b0, 0},
        '{-1, -1, 0, 0, 1'b0, 0},
        '{1234, -567, -890, 321, 1'b0, 0},
        '{-2048, 2047, -2047, 2046, 1'b0, 0},
        '{0, 0, 1000, -577, 1'b0, 0},
        '{0, 0, -1000, 577, 1'b0, 0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    t_coord             i_ref_x;
    t_coord             i_ref_y;
    t_coord             i_pt_x;
    t_coord             i_pt_y;
    logic               o_valid;
    logic               i_ready;
    logic [ANGLE_W-1:0] o_angle_deg;

    logic [63:0]        tan_q34 [0:89];
    t_angle_entry       pending_angles[$];
    int                 accepted_count;
    int                 mismatch_count;
    int                 cycle_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    point_angle_degrees DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ref_x     (i_ref_x),
        .i_ref_y     (i_ref_y),
        .i_pt_x      (i_pt_x),
        .i_pt_y      (i_pt_y),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_angle_deg (o_angle_deg)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count > LIMIT_CYCLES);
        $display("testbench failed");
        $finish;
    end

    // (a * b) >> 60, kept to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // floor(num * 2^bits / den)
    function automatic logic [63:0] scaled_quotient(input logic [63:0] num,
                                                    input logic [63:0] den, input int bits);
        logic [63:0] q;
        logic [63:0] r;
        int          n;
        q = num / den;
        r = num % den;
        for (n = 0; n < bits; n++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // tangent per whole degree with 34 fraction bits, from sine and cosine series
    function automatic void build_tangent_table();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] st;
        logic [63:0] c;
        logic [63:0] ct;
        int          k;
        int          i;
        tan_q34[0] = 64'd0;
        for (k = 1; k < 90; k++) begin
            x  = scaled_quotient(64'(k) * 64'd31415926535, 64'd1800000000000, 60);
            x2 = mul_q60(x, x);
            s  = x;
            st = x;
            c  = 64'd1 << 60;
            ct = 64'd1 << 60;
            for (i = 1; i <= 16; i++) begin
                st = mul_q60(st, x2) / 64'((2 * i) * (2 * i + 1));
                ct = mul_q60(ct, x2) / 64'((2 * i - 1) * (2 * i));
                if (i % 2 == 1) begin
                    s = s - st;
                    c = c - ct;
                end else begin
                    s = s + st;
                    c = c + ct;
                end
            end
            tan_q34[k] = (c == 64'd0) ? '1 : scaled_quotient(s, c, 34);
        end
    endfunction

    // expected direction in whole degrees from reference to checked point
    function automatic logic [ANGLE_W-1:0] predict_angle(input t_coord rx, input t_coord ry,
                                                         input t_coord px, input t_coord py);
        int          dx;
        int          dy;
        logic [63:0] adx;
        logic [63:0] ady;
        int          f;
        int          ang;
        int          k;
        dx  = int'(px) - int'(rx);
        dy  = int'(ry) - int'(py);
        adx = 64'((dx < 0) ? -dx : dx);
        ady = 64'((dy < 0) ? -dy : dy);
        f   = 0;
        for (k = 1; k < 90; k++) begin
            if ((ady << 34) >= adx * tan_q34[k]) f++;
        end
        if (dy == 0) begin
            ang = (dx < 0) ? 180 : 0;
        end else if (dx == 0) begin
            ang = (dy > 0) ? 90 : 270;
        end else if (dx > 0 && dy > 0) begin
            ang = f;
        end else if (dx < 0 && dy > 0) begin
            ang = 180 - f;
        end else if (dx < 0) begin
            ang = 180 + f;
        end else begin
            ang = 360 - f;
        end
        if (ang >= 360) ang = 0;
        return ANGLE_W'(ang);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("%s", what);
    endtask

    // pick a reference point so that ref + (dx, -dy) stays in range
    task automatic place_offset(input int dx, input int dy, output t_coord rx, output t_coord ry,
                                output t_coord px, output t_coord py);
        int lo;
        int hi;
        int x0;
        int y0;
        lo = (dx < 0) ? -2048 - dx : -2048;
        hi = (dx > 0) ? 2047 - dx : 2047;
        x0 = lo + int'($urandom_range(hi - lo));
        lo = (dy > 0) ? -2048 + dy : -2048;
        hi = (dy < 0) ? 2047 + dy : 2047;
        y0 = lo + int'($urandom_range(hi - lo));
        rx = COORD_BITS'(x0);
        ry = COORD_BITS'(y0);
        px = COORD_BITS'(x0 + dx);
        py = COORD_BITS'(y0 - dy);
    endtask

    // random point pair: full range, short offsets, or ratios on a tangent boundary
    task automatic make_random_points(output t_coord rx, output t_coord ry,
                                      output t_coord px, output t_coord py);
        int          mode;
        int          k;
        int          dx;
        int          dy;
        logic [63:0] upper;
        mode = int'($urandom_range(99));
        if (mode < 35) begin
            rx = COORD_BITS'($urandom);
            ry = COORD_BITS'($urandom);
            px = COORD_BITS'($urandom);
            py = COORD_BITS'($urandom);
        end else begin
            if (mode < 55) begin
                dx = int'($urandom_range(6)) - 3;
                dy = int'($urandom_range(6)) - 3;
            end else begin
                k     = int'($urandom_range(89, 1));
                upper = (64'd4094 << 34) / tan_q34[k];
                if (upper > 64'd4095) upper = 64'd4095;
                if (upper < 64'd1) upper = 64'd1;
                dx = int'($urandom_range(int'(upper), 1));
                dy = int'((64'(dx) * tan_q34[k]) >> 34) + int'($urandom_range(2)) - 1;
                if (dy < 0) dy = 0;
                if ($urandom_range(1)) dx = -dx;
                if ($urandom_range(1)) dy = -dy;
            end
            place_offset(dx, dy, rx, ry, px, py);
        end
    endtask

    // drive one transaction from a falling edge, with random idle cycles first
    task automatic send_points(input t_coord rx, input t_coord ry, input t_coord px,
                               input t_coord py, input logic [ANGLE_W-1:0] angle);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ref_x <= rx;
        i_ref_y <= ry;
        i_pt_x  <= px;
        i_pt_y  <= py;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        pending_angles.push_back('{angle: angle, seq: accepted_count});
        accepted_count++;
        @(negedge i_clk);
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        i_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_angle_entry want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_angles.size() == 0) begin
                report_mismatch($sformatf("unexpected result angle %0d at cycle %0d",
                                          o_angle_deg, cycle_count));
            end else begin
                want = pending_angles.pop_front();
                if (o_angle_deg !== want.angle) begin
                    report_mismatch($sformatf("item %0d: angle %0d, expected %0d",
                                              want.seq, o_angle_deg, want.angle));
                end
            end
        end
    end

    // stimulus
    initial begin
        t_coord             rx;
        t_coord             ry;
        t_coord             px;
        t_coord             py;
        logic [ANGLE_W-1:0] want;
        int                 row;
        int                 phase;
        int                 n;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b1;
        i_ref_x        = '0;
        i_ref_y        = '0;
        i_pt_x         = '0;
        i_pt_y         = '0;
        accepted_count = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        build_tangent_table();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows, no idling
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            want = DIRECTED[row].typed ? DIRECTED[row].angle
                 : predict_angle(DIRECTED[row].rx, DIRECTED[row].ry,
                                 DIRECTED[row].px, DIRECTED[row].py);
            send_points(DIRECTED[row].rx, DIRECTED[row].ry, DIRECTED[row].px,
                        DIRECTED[row].py, want);
        end

        // random traffic, one idling pattern per phase
        for (phase = 0; phase < PHASES; phase++) begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            for (n = 0; n < RANDOM_POINTS / PHASES; n++) begin
                make_random_points(rx, ry, px, py);
                send_points(rx, ry, px, py, predict_angle(rx, ry, px, py));
            end
        end
        i_valid <= 1'b0;

        // drain
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_angles.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/pad_pkg.sv
design/pad_front.sv
design/pad_search.sv
design/pad_angle.sv
design/point_angle_degrees.sv
tb/sv/testbench.sv
